// File: src/diurnal_parallax_correction_top_defines.svh
// Assertion macros shared by the parallax correction block.
`ifndef DIURNAL_PARALLAX_CORRECTION_TOP_DEFINES_SVH
`define DIURNAL_PARALLAX_CORRECTION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DPC_ASSERT(lbl, prop, msg)
`define DPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/dpc_pkg.sv
package dpc_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int TAB_LEN = 40;
   localparam int LAT_SC = CORDIC_STAGES + 2;
   localparam int ST_LAST = 3 * CORDIC_STAGES + 17;

   localparam logic [39:0] SKIP_RESET = 40'd944248560025;
   localparam logic [31:0] AU_RESET = 32'd1537133183;

   localparam logic REG_SKIP_DISTANCE = 1'b0;
   localparam logic REG_AU_RATIO = 1'b1;

   localparam logic signed [63:0] QUARTER = 64'sh1000_0000_0000_0000;
   localparam logic signed [63:0] HALFTURN = 64'sh2000_0000_0000_0000;
   localparam logic signed [63:0] ROUND30 = 64'sd536870912;
   localparam logic signed [63:0] DEC_LIMIT = 64'sd1073741824;

   typedef enum logic {MODE_ROTATE, MODE_VECTOR} mode_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic [63:0] aux;
      logic [1:0] flags;
   } cordic_type;

   function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den,
                                                int bits);
      longint unsigned r;
      longint unsigned q;
      r = num;
      q = 0;
      for (int i = 0; i < bits; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic longint atan_recip(longint unsigned m);
      longint unsigned p;
      longint unsigned n;
      longint s;
      longint term;
      p = udiv(64'h1000_0000_0000_0000, m);
      n = 1;
      s = 0;
      while (p != 0) begin
         term = longint'(udiv(p, n));
         if (n[1]) s = s - term;
         else s = s + term;
         p = udiv(udiv(p, m), m);
         n = n + 2;
      end
      return s;
   endfunction

   function automatic longint rad_entry(int i);
      longint r;
      if (i == 0) r = atan_recip(64'd2) + atan_recip(64'd3);
      else r = atan_recip(64'd1 << i);
      return r;
   endfunction

   function automatic longint atan_entry(int i);
      longint unsigned twopi;
      twopi = longint'(rad_entry(0)) * 8;
      return longint'(frac_div(rad_entry(i), twopi, 62));
   endfunction

   function automatic longint gain_factor(int bits);
      longint x;
      longint y;
      longint dx;
      longint dy;
      x = 64'sh1000_0000_0000_0000;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
         end else begin
            x = x - dx;
            y = y + dy;
         end
      end
      return longint'(frac_div(64'h1000_0000_0000_0000, x, bits));
   endfunction

   localparam logic signed [63:0] GAIN_K60 = gain_factor(60);
   localparam logic signed [63:0] GAIN_K30 = gain_factor(30);

endpackage

// File: src/dpc_cell.sv
module dpc_cell import dpc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  mode_type           mode,
   input  logic [5:0]         shift,
   input  logic signed [63:0] angle_step,
   input  cordic_type         src,
   output cordic_type         dst
);

   logic signed [63:0] dx;
   logic signed [63:0] dy;
   logic sub_x;
   cordic_type cell_in;
   cordic_type cell_ff;

   always_comb begin
      dx = $signed(src.y) >>> shift;
      dy = $signed(src.x) >>> shift;
      unique case (mode)
         MODE_ROTATE: sub_x = !src.z[63];
         MODE_VECTOR: sub_x = !($signed(src.y) > 64'sd0);
         default:     sub_x = 1'b0;
      endcase
      cell_in = src;
      if (sub_x) begin
         cell_in.x = src.x - dx;
         cell_in.y = src.y + dy;
         cell_in.z = src.z - angle_step;
      end else begin
         cell_in.x = src.x + dx;
         cell_in.y = src.y - dy;
         cell_in.z = src.z + angle_step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign dst = cell_ff;

endmodule

// File: src/dpc_chain.sv
module dpc_chain import dpc_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  mode_type   mode,
   input  cordic_type src,
   output cordic_type dst
);

   cordic_type link [0:CORDIC_STAGES];

   assign link[0] = src;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      localparam logic signed [63:0] STEP = atan_entry(i);
      dpc_cell u_cell (
         .clock      (clock),
         .en         (en),
         .mode       (mode),
         .shift      (6'(i)),
         .angle_step (STEP),
         .src        (link[i]),
         .dst        (link[i+1])
      );
   end

   assign dst = link[CORDIC_STAGES];

endmodule

// File: src/dpc_sincos.sv
module dpc_sincos import dpc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        angle,
   output logic signed [31:0] cos_o,
   output logic signed [31:0] sin_o
);

   logic signed [63:0] z_full;
   cordic_type pre_in;
   cordic_type pre_ff;
   cordic_type rot_out;
   logic signed [63:0] xr;
   logic signed [63:0] yr;
   logic [31:0] cos_in;
   logic [31:0] sin_in;
   logic [31:0] cos_ff;
   logic [31:0] sin_ff;

   always_comb begin
      z_full = {{2{angle[31]}}, angle, 30'b0};
      pre_in = '0;
      pre_in.x = GAIN_K60;
      pre_in.z = z_full;
      if (z_full > QUARTER) begin
         pre_in.z = z_full - HALFTURN;
         pre_in.flags[0] = 1'b1;
      end else if (z_full < -QUARTER) begin
         pre_in.z = z_full + HALFTURN;
         pre_in.flags[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) pre_ff <= pre_in;
   end

   dpc_chain u_chain (
      .clock (clock),
      .en    (en),
      .mode  (MODE_ROTATE),
      .src   (pre_ff),
      .dst   (rot_out)
   );

   always_comb begin
      xr = ($signed(rot_out.x) + ROUND30) >>> 30;
      yr = ($signed(rot_out.y) + ROUND30) >>> 30;
      cos_in = rot_out.flags[0] ? -xr[31:0] : xr[31:0];
      sin_in = rot_out.flags[0] ? -yr[31:0] : yr[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_o = $signed(cos_ff);
   assign sin_o = $signed(sin_ff);

endmodule

// File: src/dpc_mul30.sv
module dpc_mul30 import dpc_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   input  logic signed [31:0] c,
   output logic signed [63:0] p
);

   logic [63:0] ua;
   logic [31:0] uc;
   logic [61:0] hi_in;
   logic [63:0] lo_in;
   logic [61:0] hi_ff;
   logic [63:0] lo_ff;
   logic neg_ff;
   logic [63:0] mag;
   logic [63:0] p_ff;

   always_comb begin
      ua = a[63] ? -a : a;
      uc = c[31] ? -c : c;
      hi_in = ua[61:32] * uc;
      lo_in = ua[31:0] * uc;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         neg_ff <= a[63] ^ c[31];
      end
   end

   assign mag = {hi_ff, 2'b00} + (lo_ff >> 30);

   always_ff @(posedge clock) begin
      if (en) p_ff <= neg_ff ? -mag : mag;
   end

   assign p = $signed(p_ff);

endmodule

// File: src/diurnal_parallax_correction_top.sv
// Throughput: one word per cycle while results are taken; the rows of CORDIC cells are fully unrolled.
// A result that is not taken stalls the whole pipeline until it is taken.
// Reset clears the pipeline valid bits and restores both configuration registers.
`include "diurnal_parallax_correction_top_defines.svh"

module diurnal_parallax_correction_top import dpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sidereal_angle, observer_latitude, observer_radius, object_distance,
   // right_ascension, declination
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // corrected_ascension, corrected_declination
   output logic [63:0]  rsp_tdata,
   // skipped
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [39:0]  csr_wdata
);

   typedef struct packed {
      logic [31:0] dec;
      logic [31:0] ra;
      logic [39:0] obj_dist;
      logic [31:0] rho;
      logic [31:0] lat;
      logic [31:0] lst;
   } req_type;

   typedef struct packed {
      logic skip;
      logic [31:0] ra;
      logic [31:0] dec;
   } side_type;

   typedef struct packed {
      logic [39:0] obj_dist;
      logic [31:0] rho;
   } geo_type;

   typedef struct packed {
      logic signed [31:0] cr;
      logic signed [31:0] sr;
      logic signed [31:0] cd;
      logic signed [31:0] sd;
      logic signed [31:0] cl;
      logic signed [31:0] sl;
      logic signed [31:0] ct;
      logic signed [31:0] st;
   } trig_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } vec_type;

   typedef struct packed {
      logic right;
      logic [5:0] amount;
      logic zero;
   } norm_type;

   logic [39:0] skip_dist_ff;
   logic [31:0] au_ratio_ff;
   logic en;
   logic [ST_LAST:0] vld_ff;
   req_type req_word;
   side_type side_ff [0:ST_LAST-1];
   geo_type geo_ff [0:LAT_SC];
   logic [31:0] lst_ff;
   logic [31:0] lat_ff;

   logic signed [31:0] cr, sr, cd, sd, cl, sl, ct, st;
   trig_type trig_in;
   trig_type trig0_ff, trig1_ff, trig2_ff, trig3_ff;
   logic [51:0] dphi_ff;
   logic [51:0] dplo_ff;
   logic [35:0] r0_ff;
   logic [35:0] r1_ff;
   logic signed [63:0] d_ff;
   logic signed [63:0] r_ext;
   logic signed [63:0] t1, t2, z1, z2, u1, u2, v1, v2;
   logic signed [63:0] zd1a_ff, zd1b_ff, zd2a_ff, zd2b_ff;
   vec_type xyz0_ff, xyz1_ff, xyz2_ff;
   logic [63:0] mag_or_in;
   logic [63:0] mag_or_ff;
   logic [6:0] bitlen;
   norm_type norm_in;
   norm_type norm_ff;
   vec_type xyz3_in;
   vec_type xyz3_ff;
   logic zero3_ff;
   cordic_type vec1_in;
   cordic_type vec1_ff;
   cordic_type vec1_out;
   cordic_type g1_ff, g2_ff;
   logic signed [63:0] gprod;
   logic signed [63:0] ra_full;
   cordic_type vec2_in;
   cordic_type vec2_ff;
   cordic_type vec2_out;
   logic signed [63:0] dec_full;
   logic [31:0] dec_clamped;
   logic [31:0] rsp_ra_in, rsp_dec_in;
   logic rsp_skip_in;
   logic [31:0] rsp_ra_ff, rsp_dec_ff;
   logic rsp_skip_ff;
   logic dec_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_dist_ff <= SKIP_RESET;
         au_ratio_ff <= AU_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SKIP_DISTANCE: skip_dist_ff <= csr_wdata;
            REG_AU_RATIO:      au_ratio_ff <= csr_wdata[31:0];
            default:           ;
         endcase
      end
   end

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign req_word = req_type'(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[ST_LAST-1:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{skip: req_word.obj_dist > skip_dist_ff, ra: req_word.ra,
                         dec: req_word.dec};
         geo_ff[0] <= '{obj_dist: req_word.obj_dist, rho: req_word.rho};
         lst_ff <= req_word.lst;
         lat_ff <= req_word.lat;
         for (int k = 1; k < ST_LAST; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 1; k <= LAT_SC; k++) geo_ff[k] <= geo_ff[k-1];
      end
   end

   dpc_sincos u_sc_ra (.clock(clock), .en(en), .angle(side_ff[0].ra), .cos_o(cr), .sin_o(sr));
   dpc_sincos u_sc_dec (.clock(clock), .en(en), .angle(side_ff[0].dec), .cos_o(cd), .sin_o(sd));
   dpc_sincos u_sc_lat (.clock(clock), .en(en), .angle(lat_ff), .cos_o(cl), .sin_o(sl));
   dpc_sincos u_sc_lst (.clock(clock), .en(en), .angle(lst_ff), .cos_o(ct), .sin_o(st));

   assign trig_in = '{cr: cr, sr: sr, cd: cd, sd: sd, cl: cl, sl: sl, ct: ct, st: st};

   always_ff @(posedge clock) begin
      if (en) begin
         dphi_ff <= geo_ff[LAT_SC].obj_dist[39:20] * au_ratio_ff;
         dplo_ff <= geo_ff[LAT_SC].obj_dist[19:0] * au_ratio_ff;
         r0_ff <= {geo_ff[LAT_SC].rho, 4'b0000};
         trig0_ff <= trig_in;
         d_ff <= $signed({3'b000, dphi_ff, 9'b0} + 64'(dplo_ff >> 11));
         r1_ff <= r0_ff;
         trig1_ff <= trig0_ff;
         trig2_ff <= trig1_ff;
         trig3_ff <= trig2_ff;
      end
   end

   assign r_ext = $signed({28'b0, r1_ff});

   dpc_mul30 u_mul_t1 (.clock(clock), .en(en), .a(d_ff), .c(trig1_ff.cd), .p(t1));
   dpc_mul30 u_mul_t2 (.clock(clock), .en(en), .a(r_ext), .c(trig1_ff.cl), .p(t2));
   dpc_mul30 u_mul_z1 (.clock(clock), .en(en), .a(d_ff), .c(trig1_ff.sd), .p(z1));
   dpc_mul30 u_mul_z2 (.clock(clock), .en(en), .a(r_ext), .c(trig1_ff.sl), .p(z2));

   dpc_mul30 u_mul_u1 (.clock(clock), .en(en), .a(t1), .c(trig3_ff.cr), .p(u1));
   dpc_mul30 u_mul_u2 (.clock(clock), .en(en), .a(t2), .c(trig3_ff.ct), .p(u2));
   dpc_mul30 u_mul_v1 (.clock(clock), .en(en), .a(t1), .c(trig3_ff.sr), .p(v1));
   dpc_mul30 u_mul_v2 (.clock(clock), .en(en), .a(t2), .c(trig3_ff.st), .p(v2));

   always_comb begin
      mag_or_in = (xyz0_ff.x[63] ? -xyz0_ff.x : xyz0_ff.x)
                | (xyz0_ff.y[63] ? -xyz0_ff.y : xyz0_ff.y)
                | (xyz0_ff.z[63] ? -xyz0_ff.z : xyz0_ff.z);
   end

   always_comb begin
      bitlen = '0;
      for (int i = 0; i < 64; i++) begin
         if (mag_or_ff[i]) bitlen = 7'(i + 1);
      end
      norm_in.zero = (bitlen == 7'd0);
      norm_in.right = (bitlen > 7'd59);
      if (bitlen > 7'd59) norm_in.amount = 6'(bitlen - 7'd59);
      else norm_in.amount = 6'(7'd59 - bitlen);
   end

   always_comb begin
      if (norm_ff.right) begin
         xyz3_in.x = xyz2_ff.x >>> norm_ff.amount;
         xyz3_in.y = xyz2_ff.y >>> norm_ff.amount;
         xyz3_in.z = xyz2_ff.z >>> norm_ff.amount;
      end else begin
         xyz3_in.x = xyz2_ff.x <<< norm_ff.amount;
         xyz3_in.y = xyz2_ff.y <<< norm_ff.amount;
         xyz3_in.z = xyz2_ff.z <<< norm_ff.amount;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zd1a_ff <= z1;
         zd2a_ff <= z2;
         zd1b_ff <= zd1a_ff;
         zd2b_ff <= zd2a_ff;
         xyz0_ff <= '{x: u1 - u2, y: v1 - v2, z: zd1b_ff - zd2b_ff};
         mag_or_ff <= mag_or_in;
         xyz1_ff <= xyz0_ff;
         norm_ff <= norm_in;
         xyz2_ff <= xyz1_ff;
         xyz3_ff <= xyz3_in;
         zero3_ff <= norm_ff.zero;
      end
   end

   always_comb begin
      vec1_in = '0;
      vec1_in.x = xyz3_ff.x;
      vec1_in.y = xyz3_ff.y;
      vec1_in.aux = xyz3_ff.z;
      vec1_in.flags = {zero3_ff, 1'b0};
      if (xyz3_ff.x == 64'sd0 && xyz3_ff.y == 64'sd0) begin
         vec1_in.flags[0] = 1'b1;
      end else if (xyz3_ff.x[63]) begin
         if (!xyz3_ff.y[63]) begin
            vec1_in.x = xyz3_ff.y;
            vec1_in.y = -xyz3_ff.x;
            vec1_in.z = QUARTER;
         end else begin
            vec1_in.x = -xyz3_ff.y;
            vec1_in.y = xyz3_ff.x;
            vec1_in.z = -QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) vec1_ff <= vec1_in;
   end

   dpc_chain u_vec1 (.clock(clock), .en(en), .mode(MODE_VECTOR), .src(vec1_ff), .dst(vec1_out));

   dpc_mul30 u_mul_gain (.clock(clock), .en(en), .a(vec1_out.x), .c(GAIN_K30[31:0]),
                         .p(gprod));

   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff <= vec1_out;
         g2_ff <= g1_ff;
      end
   end

   always_comb begin
      ra_full = ($signed(g2_ff.z) + ROUND30) >>> 30;
      vec2_in = '0;
      vec2_in.flags = g2_ff.flags;
      vec2_in.y = $signed(g2_ff.aux);
      if (!g2_ff.flags[0]) begin
         vec2_in.x = gprod;
         vec2_in.aux = {32'b0, ra_full[31:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) vec2_ff <= vec2_in;
   end

   dpc_chain u_vec2 (.clock(clock), .en(en), .mode(MODE_VECTOR), .src(vec2_ff), .dst(vec2_out));

   always_comb begin
      dec_full = ($signed(vec2_out.z) + ROUND30) >>> 30;
      if (dec_full > DEC_LIMIT) dec_clamped = DEC_LIMIT[31:0];
      else if (dec_full < -DEC_LIMIT) dec_clamped = 32'(-DEC_LIMIT);
      else dec_clamped = dec_full[31:0];
      priority if (side_ff[ST_LAST-1].skip) begin
         rsp_ra_in = side_ff[ST_LAST-1].ra;
         rsp_dec_in = side_ff[ST_LAST-1].dec;
         rsp_skip_in = 1'b1;
      end else if (vec2_out.flags[1]) begin
         rsp_ra_in = '0;
         rsp_dec_in = '0;
         rsp_skip_in = 1'b0;
      end else begin
         rsp_ra_in = vec2_out.aux[31:0];
         rsp_dec_in = dec_clamped;
         rsp_skip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ra_ff <= rsp_ra_in;
         rsp_dec_ff <= rsp_dec_in;
         rsp_skip_ff <= rsp_skip_in;
      end
   end

   assign rsp_tvalid = vld_ff[ST_LAST];
   assign rsp_tdata = {rsp_dec_ff, rsp_ra_ff};
   assign rsp_tuser = rsp_skip_ff;

   assign dec_in_range = ($signed(rsp_dec_ff) <= 32'sd1073741824)
                      && ($signed(rsp_dec_ff) >= -32'sd1073741824);

   `DPC_ASSERT(a_ready_when_empty, !rsp_tvalid |-> req_tready, "Input stalled with empty output")
   `DPC_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_tvalid, "Result valid after reset")
   `DPC_ASSERT(a_stall_freezes, rsp_tvalid && !rsp_tready |=> $stable(vld_ff), "Pipeline moved")
   `DPC_ASSERT(a_dec_range, rsp_tvalid && !rsp_tuser |-> dec_in_range, "Declination out of range")

endmodule
